[rtl/optk_pkg.sv]
package optk_pkg;

   // Result kinds carried in the low bits of the result beat.
   typedef enum logic [2:0] {
      KIND_CHAR    = 3'd0,
      KIND_FEND    = 3'd1,
      KIND_DOLLAR  = 3'd2,
      KIND_DCOLON  = 3'd3,
      KIND_TCOLON  = 3'd4,
      KIND_AT      = 3'd5,
      KIND_PEND    = 3'd6
   } kind_type;

   // Which quote opened the current literal run.
   typedef enum logic [1:0] {
      QUOTE_NONE     = 2'd0,
      QUOTE_SINGLE   = 2'd1,
      QUOTE_DOUBLE   = 2'd2,
      QUOTE_BACKTICK = 2'd3
   } quote_type;

   // Bracket that the next character may swallow.
   typedef enum logic [1:0] {
      DROP_NONE  = 2'd0,
      DROP_OPEN  = 2'd1,
      DROP_CLOSE = 2'd2
   } drop_type;

   localparam int MAX_RESULTS = 4;

   // Character codes the tokenizer reacts to.
   localparam logic [15:0] CH_DOLLAR    = 16'h0024;
   localparam logic [15:0] CH_LBRACKET  = 16'h005B;
   localparam logic [15:0] CH_RBRACKET  = 16'h005D;
   localparam logic [15:0] CH_COLON     = 16'h003A;
   localparam logic [15:0] CH_AT        = 16'h0040;
   localparam logic [15:0] CH_BACKTICK  = 16'h0060;
   localparam logic [15:0] CH_SQUOTE    = 16'h0027;
   localparam logic [15:0] CH_DQUOTE    = 16'h0022;
   localparam logic [15:0] CH_BACKSLASH = 16'h005C;
   localparam logic [15:0] CH_LOWER_T   = 16'h0074;
   localparam logic [15:0] CH_LOWER_N   = 16'h006E;
   localparam logic [15:0] CH_TAB       = 16'h0009;
   localparam logic [15:0] CH_NEWLINE   = 16'h000A;

   // Tokenizer state carried from one character to the next.
   typedef struct packed {
      quote_type   quote_kind;
      logic        escape_pending;
      logic        in_brackets;
      drop_type    drop_next_bracket;
      logic [1:0]  colon_count;
      logic        fragment_nonempty;
   } state_type;

   typedef struct packed {
      kind_type    kind;
      logic [15:0] char_code;
   } slot_type;

   // Up to four results caused by one character, slot 0 first.
   typedef struct packed {
      logic [2:0]    count;
      slot_type [MAX_RESULTS-1:0] slot;
   } burst_type;

endpackage

[rtl/object_path_tokenizer_core.sv]
// Object path tokenizer.
// Characters of a path enter on the req_ channel, one per beat, with tlast on
// the final character. Tokens leave on the rsp_ channel: fragment characters,
// fragment ends, separators and a path-end mark, with tlast on the final
// beat that one character causes. A character may cause no beat at all.
// A character accepted on req_ is held in the input register, decoded into the
// result buffer, and its first token is offered from the head of that buffer.
// Throughput: one character per cycle while each causes at most one token and
// rsp_tready stays high; a character that causes more holds the decoder while
// the result buffer drains one token per cycle through a single output port.
// An input register parts the two channels, so one character is taken while
// tokens still wait. When the receiver stalls, the result buffer holds its
// tokens, the input register fills, and req_tready falls.
// Reset is synchronous and active high: it empties both registers and
// returns the tokenizer to the unquoted, empty-fragment state.
module object_path_tokenizer_core #(
   parameter int CHAR_WIDTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] ch
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [2:0] kind, [18:3] char_code, [23:19] zero
   output logic        rsp_tlast
);

   localparam int CW = (CHAR_WIDTH < 16) ? CHAR_WIDTH : 16;

   logic                in_valid_ff, in_valid_in;
   logic [CW-1:0]       in_ch_ff;
   logic                in_last_ff;
   optk_pkg::state_type state_ff, state_in;
   optk_pkg::burst_type burst_ff, burst_in;
   optk_pkg::burst_type step_burst;
   optk_pkg::state_type step_state;
   logic                advance;
   logic                take;

   // Decode the held character against the current state.
   optk_step u_step (
      .state_cur  (state_ff),
      .ch         (16'(in_ch_ff)),
      .last       (in_last_ff),
      .state_next (step_state),
      .burst      (step_burst)
   );

   // The held character moves on once the buffer is empty or about to be.
   assign take       = rsp_tvalid && rsp_tready;
   assign advance    = in_valid_ff && ((burst_ff.count == 3'd0) ||
                       (burst_ff.count == 3'd1 && rsp_tready));
   assign req_tready = !in_valid_ff || advance;

   assign in_valid_in = (req_tvalid && req_tready) ? 1'b1 :
                        (advance ? 1'b0 : in_valid_ff);

   // Next buffer: load a fresh burst, or shift out the taken token.
   always_comb begin
      burst_in = burst_ff;
      state_in = state_ff;
      if (advance) begin
         burst_in = step_burst;
         state_in = step_state;
      end else if (take) begin
         for (int i = 0; i < optk_pkg::MAX_RESULTS - 1; i++) begin
            burst_in.slot[i] = burst_ff.slot[i+1];
         end
         burst_in.count = burst_ff.count - 3'd1;
      end
   end

   // Control state and the result buffer.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         state_ff    <= '0;
         burst_ff    <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         state_ff    <= state_in;
         burst_ff    <= burst_in;
      end
   end

   // Input payload register.
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_ch_ff   <= req_tdata[CW-1:0];
         in_last_ff <= req_tlast;
      end
   end

   // The head of the buffer is the outgoing beat.
   assign rsp_tvalid = (burst_ff.count != 3'd0);
   assign rsp_tlast  = (burst_ff.count == 3'd1);
   assign rsp_tdata  = {5'd0, burst_ff.slot[0].char_code, burst_ff.slot[0].kind};

endmodule

[rtl/optk_step.sv]
module optk_step (
   input  optk_pkg::state_type state_cur,
   input  logic [15:0]         ch,
   input  logic                last,
   output optk_pkg::state_type state_next,
   output optk_pkg::burst_type burst
);

   // Append one result unless the burst is already full.
   function automatic optk_pkg::burst_type push(
      optk_pkg::burst_type b,
      optk_pkg::kind_type  k,
      logic [15:0]         code
   );
      optk_pkg::burst_type r;
      r = b;
      if (b.count < 3'(optk_pkg::MAX_RESULTS)) begin
         r.slot[b.count[1:0]].kind      = k;
         r.slot[b.count[1:0]].char_code = code;
         r.count                        = b.count + 3'd1;
      end
      return r;
   endfunction

   function automatic optk_pkg::quote_type quote_of(logic [15:0] c);
      optk_pkg::quote_type q;
      q = optk_pkg::QUOTE_NONE;
      if (c == optk_pkg::CH_SQUOTE) q = optk_pkg::QUOTE_SINGLE;
      else if (c == optk_pkg::CH_DQUOTE) q = optk_pkg::QUOTE_DOUBLE;
      else if (c == optk_pkg::CH_BACKTICK) q = optk_pkg::QUOTE_BACKTICK;
      return q;
   endfunction

   optk_pkg::state_type st;
   optk_pkg::burst_type b;
   optk_pkg::quote_type q;
   logic                consumed;

   always_comb begin
      st       = state_cur;
      b        = '0;
      consumed = 1'b0;
      q        = quote_of(ch);

      // Settle the lookahead left by the previous character.
      if (st.colon_count != 2'd0) begin
         if (ch == optk_pkg::CH_COLON) begin
            st.colon_count = st.colon_count + 2'd1;
            if (st.colon_count == 2'd3) begin
               b              = push(b, optk_pkg::KIND_TCOLON, 16'd0);
               st.colon_count = 2'd0;
            end
            consumed = 1'b1;
         end else begin
            b              = push(b, optk_pkg::KIND_DCOLON, 16'd0);
            st.colon_count = 2'd0;
         end
      end else if (st.drop_next_bracket == optk_pkg::DROP_OPEN) begin
         st.drop_next_bracket = optk_pkg::DROP_NONE;
         consumed             = (ch == optk_pkg::CH_LBRACKET);
      end else if (st.drop_next_bracket == optk_pkg::DROP_CLOSE) begin
         st.drop_next_bracket = optk_pkg::DROP_NONE;
         consumed             = (ch == optk_pkg::CH_RBRACKET);
      end else begin
         st.drop_next_bracket = optk_pkg::DROP_NONE;
      end

      // Handle the character itself.
      if (!consumed) begin
         if (st.quote_kind == optk_pkg::QUOTE_NONE) begin
            if (q != optk_pkg::QUOTE_NONE) begin
               st.quote_kind = q;
            end else if (!st.in_brackets) begin
               if (ch == optk_pkg::CH_DOLLAR) begin
                  b                    = push(b, optk_pkg::KIND_FEND, 16'd0);
                  b                    = push(b, optk_pkg::KIND_DOLLAR, 16'd0);
                  st.fragment_nonempty = 1'b0;
               end else if (ch == optk_pkg::CH_LBRACKET) begin
                  b                    = push(b, optk_pkg::KIND_FEND, 16'd0);
                  b                    = push(b, optk_pkg::KIND_DOLLAR, 16'd0);
                  st.fragment_nonempty = 1'b0;
                  st.in_brackets       = 1'b1;
                  st.drop_next_bracket = optk_pkg::DROP_OPEN;
               end else if (ch == optk_pkg::CH_COLON) begin
                  b                    = push(b, optk_pkg::KIND_FEND, 16'd0);
                  st.fragment_nonempty = 1'b0;
                  st.colon_count       = 2'd1;
               end else if (ch == optk_pkg::CH_AT) begin
                  b                    = push(b, optk_pkg::KIND_FEND, 16'd0);
                  b                    = push(b, optk_pkg::KIND_AT, 16'd0);
                  st.fragment_nonempty = 1'b0;
               end else begin
                  b                    = push(b, optk_pkg::KIND_CHAR, ch);
                  st.fragment_nonempty = 1'b1;
               end
            end else begin
               if (ch == optk_pkg::CH_RBRACKET) begin
                  st.in_brackets       = 1'b0;
                  st.drop_next_bracket = optk_pkg::DROP_CLOSE;
               end else begin
                  b                    = push(b, optk_pkg::KIND_CHAR, ch);
                  st.fragment_nonempty = 1'b1;
               end
            end
         end else begin
            // Inside quotes: escapes and the closing quote.
            if (ch == optk_pkg::CH_BACKSLASH) begin
               st.escape_pending = ~st.escape_pending;
            end else if (st.escape_pending) begin
               if (ch == optk_pkg::CH_LOWER_T) begin
                  b = push(b, optk_pkg::KIND_CHAR, optk_pkg::CH_TAB);
               end else if (ch == optk_pkg::CH_LOWER_N) begin
                  b = push(b, optk_pkg::KIND_CHAR, optk_pkg::CH_NEWLINE);
               end else begin
                  b = push(b, optk_pkg::KIND_CHAR, optk_pkg::CH_BACKSLASH);
                  b = push(b, optk_pkg::KIND_CHAR, ch);
               end
               st.fragment_nonempty = 1'b1;
               st.escape_pending    = 1'b0;
            end else if (q != optk_pkg::QUOTE_NONE && q == st.quote_kind) begin
               st.quote_kind = optk_pkg::QUOTE_NONE;
            end else begin
               b                    = push(b, optk_pkg::KIND_CHAR, ch);
               st.fragment_nonempty = 1'b1;
            end
         end
      end

      // Close out the path and return to the idle state.
      if (last) begin
         if (st.colon_count != 2'd0) begin
            b = push(b, optk_pkg::KIND_DCOLON, 16'd0);
         end
         if (st.fragment_nonempty) begin
            b = push(b, optk_pkg::KIND_FEND, 16'd0);
         end
         b  = push(b, optk_pkg::KIND_PEND, 16'd0);
         st = '0;
      end

      state_next = st;
      burst      = b;
   end

endmodule

[verif/tb_object_path_tokenizer_core.sv]
`timescale 1ns / 1ps

module tb_object_path_tokenizer_core;

   localparam int WAIT_MAX     = 17;
   localparam int RANDOM_CHARS = 480;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 20;
   localparam int PACE_SPAN    = 40;

   // Characters that steer the tokenizer, used to bias the random text.
   localparam logic [15:0] SPECIALS [11] = '{
      optk_pkg::CH_DOLLAR, optk_pkg::CH_LBRACKET, optk_pkg::CH_RBRACKET,
      optk_pkg::CH_COLON, optk_pkg::CH_AT, optk_pkg::CH_BACKTICK,
      optk_pkg::CH_SQUOTE, optk_pkg::CH_DQUOTE, optk_pkg::CH_BACKSLASH,
      optk_pkg::CH_LOWER_T, optk_pkg::CH_LOWER_N
   };

   typedef enum {PACE_FULL, PACE_SLOW, PACE_BURSTY} pace_type;
   typedef enum {SEG_NAME, SEG_QUOTED, SEG_BRACKET, SEG_SEPARATOR} segment_type;

   typedef struct packed {
      logic [15:0] ch;
      logic        last;
   } char_beat_type;

   typedef struct packed {
      optk_pkg::kind_type kind;
      logic [15:0]        code;
      logic               last;
   } token_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = '0;   // [15:0] ch
   logic        req_tlast  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;         // [2:0] kind, [18:3] char_code, [23:19] zero
   logic        rsp_tlast;

   char_beat_type pending_chars[$];
   token_type     expected_tokens[$];
   token_type     burst_tokens[$];
   char_beat_type char_on_bus;

   // Tokenizer state as the testbench tracks it.
   optk_pkg::quote_type tk_quote;
   logic                tk_escape;
   logic                tk_in_brackets;
   optk_pkg::drop_type  tk_drop;
   logic [1:0]          tk_colons;
   logic                tk_frag;

   int       error_count    = 0;
   int       chars_queued   = 0;
   int       chars_sent     = 0;
   int       paths_sent     = 0;
   int       tokens_checked = 0;
   int       cycle_count    = 0;
   int       kind_hits [7]  = '{default: 0};
   int       send_gap       = 0;
   int       stall_left     = 0;
   pace_type send_pace      = PACE_FULL;
   pace_type recv_pace      = PACE_FULL;

   object_path_tokenizer_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   // Tokenizer prediction.

   function automatic void clear_tokenizer();
      tk_quote       = optk_pkg::QUOTE_NONE;
      tk_escape      = 1'b0;
      tk_in_brackets = 1'b0;
      tk_drop        = optk_pkg::DROP_NONE;
      tk_colons      = 2'd0;
      tk_frag        = 1'b0;
   endfunction

   // One character never yields more tokens than the output burst holds.
   function automatic void put_token(optk_pkg::kind_type kind, logic [15:0] code);
      token_type t;
      if (burst_tokens.size() < optk_pkg::MAX_RESULTS) begin
         t.kind = kind;
         t.code = code;
         t.last = 1'b0;
         burst_tokens.push_back(t);
      end
   endfunction

   function automatic void put_char(logic [15:0] code);
      put_token(optk_pkg::KIND_CHAR, code);
      tk_frag = 1'b1;
   endfunction

   function automatic void end_fragment();
      put_token(optk_pkg::KIND_FEND, '0);
      tk_frag = 1'b0;
   endfunction

   function automatic optk_pkg::quote_type quote_of(logic [15:0] c);
      case (c)
         optk_pkg::CH_SQUOTE:   return optk_pkg::QUOTE_SINGLE;
         optk_pkg::CH_DQUOTE:   return optk_pkg::QUOTE_DOUBLE;
         optk_pkg::CH_BACKTICK: return optk_pkg::QUOTE_BACKTICK;
         default:               return optk_pkg::QUOTE_NONE;
      endcase
   endfunction

   // Normal handling of a character once pending colons and brackets are settled.
   function automatic void apply_char(logic [15:0] c);
      optk_pkg::quote_type q;
      q = quote_of(c);
      if (tk_quote == optk_pkg::QUOTE_NONE) begin
         if (q != optk_pkg::QUOTE_NONE) begin
            tk_quote = q;
         end else if (!tk_in_brackets) begin
            case (c)
               optk_pkg::CH_DOLLAR: begin
                  end_fragment();
                  put_token(optk_pkg::KIND_DOLLAR, '0);
               end
               optk_pkg::CH_LBRACKET: begin
                  end_fragment();
                  put_token(optk_pkg::KIND_DOLLAR, '0);
                  tk_in_brackets = 1'b1;
                  tk_drop        = optk_pkg::DROP_OPEN;
               end
               optk_pkg::CH_COLON: begin
                  end_fragment();
                  tk_colons = 2'd1;
               end
               optk_pkg::CH_AT: begin
                  end_fragment();
                  put_token(optk_pkg::KIND_AT, '0);
               end
               default: put_char(c);
            endcase
         end else if (c == optk_pkg::CH_RBRACKET) begin
            tk_in_brackets = 1'b0;
            tk_drop        = optk_pkg::DROP_CLOSE;
         end else begin
            put_char(c);
         end
      end else if (c == optk_pkg::CH_BACKSLASH) begin
         tk_escape = ~tk_escape;
      end else if (tk_escape) begin
         if (c == optk_pkg::CH_LOWER_T) begin
            put_char(optk_pkg::CH_TAB);
         end else if (c == optk_pkg::CH_LOWER_N) begin
            put_char(optk_pkg::CH_NEWLINE);
         end else begin
            put_char(optk_pkg::CH_BACKSLASH);
            put_char(c);
         end
         tk_escape = 1'b0;
      end else if (q == tk_quote) begin
         tk_quote = optk_pkg::QUOTE_NONE;
      end else begin
         put_char(c);
      end
   endfunction

   // Works out the tokens of one accepted character and queues them.
   function automatic void tokenize_char(char_beat_type b);
      logic skip;
      skip = 1'b0;
      burst_tokens.delete();
      if (tk_colons != 2'd0) begin
         if (b.ch == optk_pkg::CH_COLON) begin
            tk_colons = tk_colons + 2'd1;
            if (tk_colons == 2'd3) begin
               put_token(optk_pkg::KIND_TCOLON, '0);
               tk_colons = 2'd0;
            end
            skip = 1'b1;
         end else begin
            put_token(optk_pkg::KIND_DCOLON, '0);
            tk_colons = 2'd0;
         end
      end else begin
         if (tk_drop == optk_pkg::DROP_OPEN && b.ch == optk_pkg::CH_LBRACKET) skip = 1'b1;
         if (tk_drop == optk_pkg::DROP_CLOSE && b.ch == optk_pkg::CH_RBRACKET) skip = 1'b1;
         tk_drop = optk_pkg::DROP_NONE;
      end
      if (!skip) apply_char(b.ch);
      if (b.last) begin
         if (tk_colons != 2'd0) put_token(optk_pkg::KIND_DCOLON, '0);
         if (tk_frag) end_fragment();
         put_token(optk_pkg::KIND_PEND, '0);
         clear_tokenizer();
      end
      if (burst_tokens.size() > 0) burst_tokens[burst_tokens.size()-1].last = 1'b1;
      foreach (burst_tokens[i]) expected_tokens.push_back(burst_tokens[i]);
   endfunction

   // Stimulus generation.

   function automatic int next_wait(pace_type pace);
      case (pace)
         PACE_FULL: return 0;
         PACE_SLOW: return $urandom_range(0, WAIT_MAX);
         default:   return ($urandom_range(0, 4) == 0) ? $urandom_range(1, WAIT_MAX) : 0;
      endcase
   endfunction

   function automatic void queue_path(input logic [15:0] codes[$]);
      char_beat_type b;
      foreach (codes[i]) begin
         b.ch   = codes[i];
         b.last = (i == codes.size() - 1);
         pending_chars.push_back(b);
      end
      chars_queued += codes.size();
   endfunction

   function automatic void queue_text(string s);
      logic [15:0] codes[$];
      for (int i = 0; i < s.len(); i++) codes.push_back(16'(s[i]));
      queue_path(codes);
   endfunction

   function automatic logic [15:0] letter();
      return 16'h0061 + 16'($urandom_range(0, 25));
   endfunction

   function automatic logic [15:0] any_char();
      case ($urandom_range(0, 3))
         0:       return 16'($urandom);
         1:       return letter();
         default: return SPECIALS[$urandom_range(0, 10)];
      endcase
   endfunction

   function automatic logic [15:0] any_quote();
      case ($urandom_range(0, 2))
         0:       return optk_pkg::CH_SQUOTE;
         1:       return optk_pkg::CH_DQUOTE;
         default: return optk_pkg::CH_BACKTICK;
      endcase
   endfunction

   // Quoted text with escapes; the closing quote is sometimes left out.
   function automatic void add_quoted(ref logic [15:0] p[$]);
      logic [15:0] q;
      q = any_quote();
      p.push_back(q);
      repeat ($urandom_range(0, 3)) begin
         case ($urandom_range(0, 5))
            0: p.push_back(letter());
            1: begin
               p.push_back(optk_pkg::CH_BACKSLASH);
               p.push_back(optk_pkg::CH_LOWER_T);
            end
            2: begin
               p.push_back(optk_pkg::CH_BACKSLASH);
               p.push_back(optk_pkg::CH_LOWER_N);
            end
            3: begin
               p.push_back(optk_pkg::CH_BACKSLASH);
               p.push_back(any_char());
            end
            4: p.push_back(any_quote());
            default: p.push_back(any_char());
         endcase
      end
      if ($urandom_range(0, 7) != 0) p.push_back(q);
   endfunction

   // Mostly well-formed paths built from segments, the rest raw noise.
   function automatic void queue_random_path();
      logic [15:0] p[$];
      if ($urandom_range(0, 3) == 0) begin
         repeat ($urandom_range(1, 8)) p.push_back(any_char());
      end else begin
         repeat ($urandom_range(1, 4)) begin
            case (segment_type'($urandom_range(0, 3)))
               SEG_NAME: begin
                  repeat ($urandom_range(1, 3))
                     p.push_back(($urandom_range(0, 5) == 0) ? 16'($urandom) : letter());
               end
               SEG_QUOTED: add_quoted(p);
               SEG_BRACKET: begin
                  p.push_back(optk_pkg::CH_LBRACKET);
                  if ($urandom_range(0, 1)) p.push_back(optk_pkg::CH_LBRACKET);
                  if ($urandom_range(0, 3) == 0) add_quoted(p);
                  else repeat ($urandom_range(1, 2)) p.push_back(letter());
                  p.push_back(optk_pkg::CH_RBRACKET);
                  if ($urandom_range(0, 1)) p.push_back(optk_pkg::CH_RBRACKET);
               end
               default: begin
                  case ($urandom_range(0, 4))
                     0: p.push_back(optk_pkg::CH_DOLLAR);
                     1: p.push_back(optk_pkg::CH_AT);
                     default: repeat ($urandom_range(1, 3)) p.push_back(optk_pkg::CH_COLON);
                  endcase
               end
            endcase
         end
      end
      queue_path(p);
   endfunction

   // Input driver: offers queued characters with random gaps between beats.
   always @(posedge clock) begin
      logic offer;
      offer = req_tvalid;
      if (reset) begin
         offer = 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            tokenize_char(char_on_bus);
            chars_sent++;
            if (char_on_bus.last) paths_sent++;
            if (chars_sent % PACE_SPAN == 0) send_pace = pace_type'($urandom_range(0, 2));
            send_gap = next_wait(send_pace);
            offer    = 1'b0;
         end
         if (!offer) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (pending_chars.size() > 0) begin
               char_on_bus = pending_chars.pop_front();
               req_tdata <= char_on_bus.ch;
               req_tlast <= char_on_bus.last;
               offer = 1'b1;
            end
         end
      end
      req_tvalid <= offer;
   end

   // Output monitor: checks each token beat and stalls the receiver at random.
   always @(posedge clock) begin
      token_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
      end else if (rsp_tvalid && rsp_tready) begin
         if (expected_tokens.size() == 0) begin
            $display("%0t: token beat with nothing expected: kind %0d code %h last %b",
                     $time, rsp_tdata[2:0], rsp_tdata[18:3], rsp_tlast);
            error_count++;
         end else begin
            want = expected_tokens.pop_front();
            kind_hits[want.kind]++;
            if (rsp_tdata[2:0] !== want.kind) begin
               $display("%0t: kind mismatch: expected %0d, actual %0d",
                        $time, want.kind, rsp_tdata[2:0]);
               error_count++;
            end
            if (rsp_tdata[18:3] !== want.code) begin
               $display("%0t: char_code mismatch: expected %h, actual %h",
                        $time, want.code, rsp_tdata[18:3]);
               error_count++;
            end
            if (rsp_tlast !== want.last) begin
               $display("%0t: last_of_run mismatch: expected %b, actual %b",
                        $time, want.last, rsp_tlast);
               error_count++;
            end
            if (rsp_tdata[23:19] !== 5'd0) begin
               $display("%0t: padding mismatch: expected 00, actual %h",
                        $time, rsp_tdata[23:19]);
               error_count++;
            end
         end
         tokens_checked++;
         if (tokens_checked % PACE_SPAN == 0) recv_pace = pace_type'($urandom_range(0, 2));
         stall_left = next_wait(recv_pace);
         rsp_tready <= (stall_left == 0);
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= (stall_left == 0);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Run stopped at the cycle limit with %0d tokens outstanding.",
                  expected_tokens.size());
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      logic [15:0] codes[$];
      clear_tokenizer();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed paths: code extremes with a double colon, a triple colon and an
      // at sign, doubled brackets with a dollar, and escapes inside an unclosed quote.
      codes = '{16'hFFFF, optk_pkg::CH_COLON, optk_pkg::CH_COLON, 16'h0000};
      queue_path(codes);
      queue_text(":::@");
      queue_text("[[k]]$");
      queue_text("\"\\t\\n\\\"\\q\\\\");

      while (chars_queued < 25 + RANDOM_CHARS) queue_random_path();

      // Wait for every character to go in and every token to come out.
      while (pending_chars.size() > 0 || req_tvalid || expected_tokens.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (expected_tokens.size() != 0) begin
         $display("%0t: %0d expected tokens never arrived", $time, expected_tokens.size());
         error_count++;
      end

      $display("Sent %0d characters in %0d paths and checked %0d tokens.",
               chars_sent, paths_sent, tokens_checked);
      $display("Tokens by kind: char %0d, fend %0d, $ %0d, :: %0d, ::: %0d, @ %0d, end %0d.",
               kind_hits[0], kind_hits[1], kind_hits[2], kind_hits[3], kind_hits[4],
               kind_hits[5], kind_hits[6]);
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
